### rtl/core/rpn_stack_calculator_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef RPN_STACK_CALCULATOR_UNIT_ASSERT_SVH
`define RPN_STACK_CALCULATOR_UNIT_ASSERT_SVH

`define RSC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define RSC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### rtl/core/rsc_pkg.sv
package rsc_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [3:0] {
    CMD_PUSH = 4'd0, CMD_ADD = 4'd1, CMD_SUB = 4'd2, CMD_MUL = 4'd3,
    CMD_DIV = 4'd4, CMD_MOD = 4'd5, CMD_NEG = 4'd6, CMD_READ = 4'd7,
    CMD_WRITE = 4'd8, CMD_NEWLINE = 4'd9, CMD_DROP = 4'd10, CMD_DUP = 4'd11,
    CMD_SWAP = 4'd12
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVF = 3'd2, ST_DIV0 = 3'd3,
    ST_INDEX = 3'd4, ST_FULL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0, PK_NUMBER = 2'd1, PK_NEWLINE = 2'd2
  } print_kind_t;

  typedef struct packed {
    logic [3:0]        cmd;
    logic signed [31:0] operand_value;
    logic [7:0]        stack_index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    print_kind_t        print_kind;
    logic signed [31:0] print_value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_DECIDE, S_ALU, S_WR2, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0, ALU_DIV = 2'd1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
    logic [31:0] quo;
    logic [31:0] rem;
  } alu_rsp_t;

endpackage

### rtl/core/rsc_alu.sv
// Shared iterative unit: unsigned 32x32 multiply (two 32x16 partial products)
// or unsigned 32/32 restoring division, one quotient bit per cycle.
module rsc_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  rsc_pkg::alu_req_t  req,
  input  logic [31:0]        opa,
  input  logic [31:0]        opb,
  output rsc_pkg::alu_rsp_t  rsp
);

  logic        busy_r, busy_nxt;
  rsc_pkg::alu_op_t op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [47:0] pp;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], a_r[31]} - {1'b0, b_r};
    pp       = a_r * b_r[15:0];
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      a_nxt    = opa;
      b_nxt    = opb;
      acc_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      if (op_r == rsc_pkg::ALU_MUL) begin
        // low half then high half of the multiplier
        if (cnt_r == 6'd0) begin
          acc_nxt = {16'd0, pp};
          b_nxt   = {16'd0, b_r[31:16]};
        end else begin
          acc_nxt  = acc_r + {pp, 16'd0};
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        a_nxt = {a_r[30:0], 1'b0};
        if (!trial[32]) begin
          rem_nxt = {1'b0, trial[31:0]};
          acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], a_r[31]};
          acc_nxt = {acc_r[62:0], 1'b0};
        end
        if (cnt_r == 6'd31) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
  assign rsp.quo  = acc_r[31:0];
  assign rsp.rem  = rem_r[31:0];

endmodule

### rtl/core/rsc_stack_mem.sv
// Stack store: one write port, one registered read port.
module rsc_stack_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/rpn_stack_calculator_unit.sv
// RPN stack calculator: one instruction per beat, one result beat each.
// Each instruction passes S_RD1, S_RD2 and S_DECIDE before S_DONE; add/sub may also use S_ALU, swap
// S_WR2, and multiply, divide and remainder may wait in S_ALU on the shared iterative unit.
// One instruction at a time; in_stall is high from acceptance until the
// result beat is taken. Synchronous active-low reset empties the stack.
module rpn_stack_calculator_unit #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsc_pkg::out_item_t out_data
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FullCnt = CW'(STACK_DEPTH);

  rsc_pkg::state_t   state_r, state_nxt;
  rsc_pkg::in_item_t item_r, item_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [31:0]       a_r, a_nxt, b_r, b_nxt;
  rsc_pkg::out_item_t res_r, res_nxt;
  logic              ov_r, ov_nxt;
  logic              aneg_r, aneg_nxt, bneg_r, bneg_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  rsc_pkg::alu_req_t areq;
  rsc_pkg::alu_rsp_t arsp;
  logic [31:0]   opa, opb;

  logic [CW-1:0] idx_ext, top_addr, deep_addr;
  logic [63:0]   sprod;
  logic [31:0]   qadj, radj, absa;
  logic          isbin, deep_ok;

  rsc_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  rsc_alu u_alu (
    .clk(clk), .rst_n(rst_n), .req(areq), .opa(opa), .opb(opb), .rsp(arsp)
  );

  assign in_stall  = (state_r != rsc_pkg::S_IDLE);
  assign out_valid = (state_r == rsc_pkg::S_DONE);
  assign out_data  = res_r;

  always_comb begin
    idx_ext   = CW'(item_r.stack_index);
    top_addr  = cnt_r - CW'(1);
    deep_addr = cnt_r - CW'(1) - idx_ext;
    // compare at full width so a small stack never truncates the index
    deep_ok   = (cnt_r != '0) && (32'(item_r.stack_index) < 32'(cnt_r));
    isbin     = (item_r.cmd == rsc_pkg::CMD_ADD) || (item_r.cmd == rsc_pkg::CMD_SUB) ||
                (item_r.cmd == rsc_pkg::CMD_MUL) || (item_r.cmd == rsc_pkg::CMD_DIV) ||
                (item_r.cmd == rsc_pkg::CMD_MOD);
    absa      = aneg_r ? (32'd0 - a_r) : a_r;
    // a_r = top (a), b_r = second (b); magnitudes fed to the shared unit
    opa = (item_r.cmd == rsc_pkg::CMD_MUL) ? (aneg_r ? 32'd0 - a_r : a_r)
                                           : (bneg_r ? 32'd0 - b_r : b_r);
    opb = (item_r.cmd == rsc_pkg::CMD_MUL) ? (bneg_r ? 32'd0 - b_r : b_r) : absa;
    sprod = (aneg_r ^ bneg_r) ? (64'd0 - arsp.prod) : arsp.prod;
    // Euclidean fixup from magnitude results
    qadj = arsp.quo;
    radj = arsp.rem;
    if (bneg_r && arsp.rem != 32'd0) begin
      qadj = arsp.quo + 32'd1;
      radj = absa - arsp.rem;
    end
    if (aneg_r ^ bneg_r) qadj = 32'd0 - qadj;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r;
    aneg_nxt  = aneg_r;
    bneg_nxt  = bneg_r;
    we        = 1'b0;
    waddr     = top_addr[AW-1:0];
    wdata     = a_r;
    raddr     = top_addr[AW-1:0];
    areq      = '{start: 1'b0, op: rsc_pkg::ALU_MUL};
    unique case (state_r)
      rsc_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = rsc_pkg::S_RD1;
        end
      end
      rsc_pkg::S_RD1: begin
        // read the top word
        raddr     = top_addr[AW-1:0];
        state_nxt = rsc_pkg::S_RD2;
      end
      rsc_pkg::S_RD2: begin
        a_nxt     = rdata;
        state_nxt = rsc_pkg::S_DECIDE;
        if (!isbin) raddr = deep_addr[AW-1:0];
        else        raddr = AW'(cnt_r - CW'(2));
      end
      rsc_pkg::S_DECIDE: begin
        b_nxt     = rdata;
        res_nxt   = '{status: rsc_pkg::ST_OK, print_kind: rsc_pkg::PK_NONE,
                      print_value: 32'sd0};
        state_nxt = rsc_pkg::S_DONE;
        case (item_r.cmd)
          rsc_pkg::CMD_PUSH, rsc_pkg::CMD_READ: begin
            if (cnt_r >= FullCnt) res_nxt.status = rsc_pkg::ST_FULL;
            else begin
              we = 1'b1; waddr = cnt_r[AW-1:0]; wdata = item_r.operand_value;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB, rsc_pkg::CMD_MUL,
          rsc_pkg::CMD_DIV, rsc_pkg::CMD_MOD: begin
            if (cnt_r < CW'(2)) res_nxt.status = rsc_pkg::ST_UNDER;
            else begin
              cnt_nxt  = cnt_r - CW'(2);
              aneg_nxt = a_r[31];
              bneg_nxt = rdata[31];
              state_nxt = rsc_pkg::S_ALU;
              if ((item_r.cmd == rsc_pkg::CMD_DIV || item_r.cmd == rsc_pkg::CMD_MOD) &&
                  a_r == 32'd0) begin
                res_nxt.status = rsc_pkg::ST_DIV0;
                state_nxt = rsc_pkg::S_DONE;
              end else if ((item_r.cmd == rsc_pkg::CMD_DIV ||
                             item_r.cmd == rsc_pkg::CMD_MOD) &&
                            a_r == 32'hFFFF_FFFF && rdata == 32'h8000_0000) begin
                res_nxt.status = rsc_pkg::ST_OVF;
                state_nxt = rsc_pkg::S_DONE;
              end
            end
          end
          rsc_pkg::CMD_NEG: begin
            if (cnt_r == '0) res_nxt.status = rsc_pkg::ST_UNDER;
            else begin
              we = 1'b1; waddr = top_addr[AW-1:0]; wdata = 32'd0 - a_r;
            end
          end
          rsc_pkg::CMD_WRITE: begin
            if (cnt_r == '0) res_nxt.status = rsc_pkg::ST_UNDER;
            else begin
              cnt_nxt = top_addr;
              res_nxt.print_kind  = rsc_pkg::PK_NUMBER;
              res_nxt.print_value = a_r;
            end
          end
          rsc_pkg::CMD_NEWLINE: res_nxt.print_kind = rsc_pkg::PK_NEWLINE;
          rsc_pkg::CMD_DROP: begin
            if (cnt_r == '0) res_nxt.status = rsc_pkg::ST_UNDER;
            else cnt_nxt = top_addr;
          end
          rsc_pkg::CMD_DUP: begin
            if (!deep_ok) res_nxt.status = rsc_pkg::ST_INDEX;
            else if (cnt_r >= FullCnt) res_nxt.status = rsc_pkg::ST_FULL;
            else begin
              we = 1'b1; waddr = cnt_r[AW-1:0]; wdata = rdata;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          rsc_pkg::CMD_SWAP: begin
            if (item_r.stack_index == 8'd0) begin
              // nothing to do
            end else if (!deep_ok) res_nxt.status = rsc_pkg::ST_INDEX;
            else begin
              we = 1'b1; waddr = top_addr[AW-1:0]; wdata = rdata;
              state_nxt = rsc_pkg::S_WR2;
            end
          end
          default: ;
        endcase
      end
      rsc_pkg::S_ALU: begin
        // a_r = a (top), b_r = b; cnt_r already lowered by two
        if (item_r.cmd == rsc_pkg::CMD_ADD || item_r.cmd == rsc_pkg::CMD_SUB) begin
          state_nxt = rsc_pkg::S_DONE;
          if (item_r.cmd == rsc_pkg::CMD_ADD) begin
            wdata  = b_r + a_r;
            ov_nxt = (b_r[31] == a_r[31]) && (wdata[31] != b_r[31]);
          end else begin
            wdata  = b_r - a_r;
            ov_nxt = (b_r[31] != a_r[31]) && (wdata[31] != b_r[31]);
          end
          if (ov_nxt) res_nxt.status = rsc_pkg::ST_OVF;
          else begin
            we = 1'b1; waddr = cnt_r[AW-1:0]; cnt_nxt = cnt_r + CW'(1);
          end
        end else if (ov_r == 1'b0 && !arsp.done) begin
          // launch once, then wait
          areq = '{start: 1'b1, op: (item_r.cmd == rsc_pkg::CMD_MUL) ?
                   rsc_pkg::ALU_MUL : rsc_pkg::ALU_DIV};
          ov_nxt = 1'b1;
        end else if (arsp.done) begin
          ov_nxt    = 1'b0;
          state_nxt = rsc_pkg::S_DONE;
          waddr = cnt_r[AW-1:0];
          if (item_r.cmd == rsc_pkg::CMD_MUL) begin
            wdata = sprod[31:0];
            if (sprod[63:31] != {33{sprod[31]}}) res_nxt.status = rsc_pkg::ST_OVF;
            else begin we = 1'b1; cnt_nxt = cnt_r + CW'(1); end
          end else begin
            wdata = (item_r.cmd == rsc_pkg::CMD_DIV) ? qadj : radj;
            we = 1'b1; cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      rsc_pkg::S_WR2: begin
        we = 1'b1; waddr = deep_addr[AW-1:0]; wdata = a_r;
        state_nxt = rsc_pkg::S_DONE;
      end
      rsc_pkg::S_DONE: begin
        if (!out_stall) state_nxt = rsc_pkg::S_IDLE;
      end
      default: state_nxt = rsc_pkg::S_IDLE;
    endcase
    if (state_r == rsc_pkg::S_ALU && (item_r.cmd == rsc_pkg::CMD_ADD ||
        item_r.cmd == rsc_pkg::CMD_SUB)) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsc_pkg::S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    item_r <= item_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    aneg_r <= aneg_nxt;
    bneg_r <= bneg_nxt;
  end

endmodule

### rtl/core/rsc_checker.sv
`include "rpn_stack_calculator_unit_assert.svh"

module rsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rsc_pkg::out_item_t out_data
);

  // accepted beat blocks input next cycle
  `RSC_ASSERT_NXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  // result held while stalled
  `RSC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // a result only shows while input is blocked
  `RSC_ASSERT_IMP(a_excl, clk, rst_n, out_valid, in_stall)
  // value printed only with a number
  `RSC_ASSERT_IMP(a_pv, clk, rst_n, out_valid && out_data.print_kind != rsc_pkg::PK_NUMBER,
                  out_data.print_value == 32'sd0)

endmodule

bind rpn_stack_calculator_unit rsc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
